// ===== rtl/iid_pkg.sv =====
// ----------------------------------------------------------------------------
// iid_pkg
// shared widths, register indexes and reset values of the idle detector
// ----------------------------------------------------------------------------
package iid_pkg;

    localparam int HistoryDepthDefault = 32;
    localparam int SampleW = 16;
    localparam int MagW = 16;
    localparam int SensW = 20;
    localparam int WinW = 6;
    localparam int LimW = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 20;

    localparam logic [CfgIdxW-1:0] RegAccelSens = 3'd0;
    localparam logic [CfgIdxW-1:0] RegGyroSens  = 3'd1;
    localparam logic [CfgIdxW-1:0] RegWindow    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegAccelLow  = 3'd3;
    localparam logic [CfgIdxW-1:0] RegAccelHigh = 3'd4;
    localparam logic [CfgIdxW-1:0] RegGyroHigh  = 3'd5;

    localparam logic [SensW-1:0] AccelSensReset = 20'd262144;
    localparam logic [SensW-1:0] GyroSensReset  = 20'd2096;
    localparam logic [WinW-1:0]  WindowReset    = 6'd32;
    localparam logic [LimW-1:0]  AccelLowReset  = 16'd500;
    localparam logic [LimW-1:0]  AccelHighReset = 16'd1500;
    localparam logic [LimW-1:0]  GyroHighReset  = 16'd500;

    // sum of squares is at most 3*2^30, times 10^6 fits 52 bits
    localparam int SqW = 33;
    localparam int ProdW = 54;
    localparam int RootW = 27;

endpackage

// ===== rtl/iid_stream_if.sv =====
// ----------------------------------------------------------------------------
// iid_stream_if
// valid/ready channel carrying one word of payload
// ----------------------------------------------------------------------------
interface iid_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/iid_mag_unit.sv =====
// ----------------------------------------------------------------------------
// iid_mag_unit
// magnitude of one three-axis sample: squares, sqrt, divide, saturate
// ----------------------------------------------------------------------------
module iid_mag_unit
    import iid_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SampleW-1:0]  ax,
    input  logic signed [SampleW-1:0]  ay,
    input  logic signed [SampleW-1:0]  az,
    input  logic [SensW-1:0]           sens,
    output logic                       done,
    output logic [MagW-1:0]            mag
);

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_SCALE, S_ROOT, S_DINIT, S_DIV, S_DONE
    } state_t;

    state_t               state_reg;
    logic [1:0]           axis_reg;
    logic [5:0]           cnt_reg;
    logic [SqW-1:0]       acc_reg;
    logic [ProdW-1:0]     rad_reg;
    logic [ProdW-1:0]     rem_reg;
    logic [RootW-1:0]     root_reg;
    logic [RootW+4-1:0]   quo_reg;
    logic [SensW:0]       drem_reg;
    logic [MagW-1:0]      mag_reg;

    logic signed [SampleW-1:0] axis_val;
    logic [2*SampleW-1:0]      sq;
    logic [ProdW-1:0]          rem_sh;
    logic [RootW+1:0]          trial;
    logic [SensW:0]            dshift;

    always_comb
    begin
        case (axis_reg)
            2'd0:    axis_val = ax;
            2'd1:    axis_val = ay;
            default: axis_val = az;
        endcase
        sq = 32'(axis_val * axis_val);
        // one radix-2 root step: bring down two bits
        rem_sh = {rem_reg[ProdW-3:0], rad_reg[ProdW-1 -: 2]};
        trial = {root_reg, 2'b01};
        // one restoring division step
        dshift = {drem_reg[SensW-1:0], quo_reg[RootW+3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        acc_reg <= '0;
                        axis_reg <= '0;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    acc_reg <= acc_reg + SqW'(sq);
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    rad_reg <= ProdW'(acc_reg) * ProdW'(1000000);
                    rem_reg <= '0;
                    root_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    rad_reg <= rad_reg << 2;
                    if (rem_sh >= ProdW'(trial))
                    begin
                        rem_reg <= rem_sh - ProdW'(trial);
                        root_reg <= {root_reg[RootW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        root_reg <= {root_reg[RootW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(RootW - 1))
                        state_reg <= S_DINIT;
                end
                S_DINIT:
                begin
                    // dividend is root times 16
                    quo_reg <= {root_reg, 4'b0};
                    drem_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (dshift >= {1'b0, sens})
                    begin
                        drem_reg <= dshift - {1'b0, sens};
                        quo_reg <= {quo_reg[RootW+2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dshift;
                        quo_reg <= {quo_reg[RootW+2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(RootW + 3))
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        if (sens == '0 || quo_reg[RootW+3:MagW] != '0)
            mag_reg = '1;
        else
            mag_reg = quo_reg[MagW-1:0];
    end

    assign done = (state_reg == S_DONE);
    assign mag = mag_reg;

endmodule

// ===== rtl/iid_window.sv =====
// ----------------------------------------------------------------------------
// iid_window
// history memories, serial window sums and limit compare
// ----------------------------------------------------------------------------
module iid_window
    import iid_pkg::*;
#(
    parameter int HISTORY_DEPTH = HistoryDepthDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MagW-1:0]  mag_a,
    input  logic [MagW-1:0]  mag_g,
    input  logic [WinW-1:0]  window,
    input  logic [LimW-1:0]  acc_low,
    input  logic [LimW-1:0]  acc_high,
    input  logic [LimW-1:0]  gyr_high,
    output logic             done,
    output logic             is_idle,
    output logic             filling
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 2);
    localparam int LW = $clog2(HISTORY_DEPTH + 1);
    localparam int SumW = MagW + LW;

    typedef enum logic [2:0] {W_IDLE, W_CLEAR, W_READ, W_ACC, W_CMP, W_DONE} state_t;

    state_t           state_reg;
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    rptr_reg;
    logic [AW-1:0]    clr_reg;
    logic [LW-1:0]    len_reg;
    logic [LW-1:0]    left_reg;
    logic [CW-1:0]    fill_reg;
    logic [SumW-1:0]  sum_a_reg;
    logic [SumW-1:0]  sum_g_reg;
    logic [MagW-1:0]  rd_a_reg;
    logic [MagW-1:0]  rd_g_reg;
    logic             idle_reg;
    logic             filling_reg;
    logic [MagW-1:0]  hist_a [HISTORY_DEPTH];
    logic [MagW-1:0]  hist_g [HISTORY_DEPTH];

    logic [LW-1:0]    len_eff;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [MagW-1:0]  wr_a;
    logic [MagW-1:0]  wr_g;

    always_comb
    begin
        if (window == '0)
            len_eff = LW'(1);
        else if (32'(window) > HISTORY_DEPTH)
            len_eff = LW'(HISTORY_DEPTH);
        else
            len_eff = LW'(window);
        wr_en = (state_reg == W_CLEAR) || (state_reg == W_IDLE && start);
        wr_addr = (state_reg == W_CLEAR) ? clr_reg : wptr_reg;
        wr_a = (state_reg == W_CLEAR) ? '0 : mag_a;
        wr_g = (state_reg == W_CLEAR) ? '0 : mag_g;
    end

    // memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_a[wr_addr] <= wr_a;
            hist_g[wr_addr] <= wr_g;
        end
        rd_a_reg <= hist_a[rptr_reg];
        rd_g_reg <= hist_g[rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_CLEAR;
            wptr_reg <= '0;
            rptr_reg <= '0;
            clr_reg <= '0;
            fill_reg <= '0;
            len_reg <= '0;
            left_reg <= '0;
            idle_reg <= 1'b0;
            filling_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                W_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == HISTORY_DEPTH - 1)
                        state_reg <= W_IDLE;
                end
                W_IDLE:
                begin
                    if (start)
                    begin
                        // newest entry sits at wptr; walk back len entries
                        wptr_reg <= (32'(wptr_reg) == HISTORY_DEPTH - 1) ? '0
                                    : wptr_reg + AW'(1);
                        rptr_reg <= wptr_reg;
                        len_reg <= len_eff;
                        left_reg <= len_eff;
                        sum_a_reg <= '0;
                        sum_g_reg <= '0;
                        if (32'(fill_reg) <= HISTORY_DEPTH)
                            fill_reg <= fill_reg + CW'(1);
                        state_reg <= W_READ;
                    end
                end
                W_READ:
                begin
                    state_reg <= W_ACC;
                end
                W_ACC:
                begin
                    sum_a_reg <= sum_a_reg + SumW'(rd_a_reg);
                    sum_g_reg <= sum_g_reg + SumW'(rd_g_reg);
                    rptr_reg <= (rptr_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                : rptr_reg - AW'(1);
                    left_reg <= left_reg - LW'(1);
                    state_reg <= (left_reg == LW'(1)) ? W_CMP : W_READ;
                end
                W_CMP:
                begin
                    filling_reg <= 32'(fill_reg) < HISTORY_DEPTH;
                    idle_reg <= (32'(fill_reg) >= HISTORY_DEPTH)
                        && (SumW'(acc_low) * SumW'(len_reg) <= sum_a_reg)
                        && (sum_a_reg <= SumW'(acc_high) * SumW'(len_reg))
                        && (sum_g_reg <= SumW'(gyr_high) * SumW'(len_reg));
                    state_reg <= W_DONE;
                end
                W_DONE:
                begin
                    state_reg <= W_IDLE;
                end
                default:
                    state_reg <= W_IDLE;
            endcase
        end
    end

    assign done = (state_reg == W_DONE);
    assign is_idle = idle_reg;
    assign filling = filling_reg;

endmodule

// ===== rtl/imu_idle_detector_top.sv =====
// throughput: one word at a time; the next is taken once the result has been taken
// the two magnitudes share one iterative root and divide unit, in turn
// window sums walk the history memory one entry at a time, a read state then an accumulate state for each
// reset: async active low; registers take their reset values, then a clearing
// pass writes zero to every history entry before the first word
// ----------------------------------------------------------------------------
// imu_idle_detector_top
// idle detector over accelerometer and gyro magnitude windows
// ----------------------------------------------------------------------------
module imu_idle_detector_top
    import iid_pkg::*;
#(
    parameter int HISTORY_DEPTH = HistoryDepthDefault
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    iid_stream_if.sink           in_ch,
    iid_stream_if.source         out_ch,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    typedef enum logic [2:0] {T_IDLE, T_MAG_A, T_MAG_G, T_WIN, T_OUT} state_t;

    state_t            state_reg;
    logic [95:0]       sample_reg;
    logic [MagW-1:0]   mag_a_reg;
    logic [SensW-1:0]  a_sens_reg;
    logic [SensW-1:0]  g_sens_reg;
    logic [WinW-1:0]   win_reg;
    logic [LimW-1:0]   a_low_reg;
    logic [LimW-1:0]   a_high_reg;
    logic [LimW-1:0]   g_high_reg;
    logic              is_idle_reg;
    logic              filling_reg;

    // shared magnitude unit: operands switch with the sensor being processed
    logic                       mag_start;
    logic                       mag_done;
    logic [MagW-1:0]            mag;
    logic signed [SampleW-1:0]  ax;
    logic signed [SampleW-1:0]  ay;
    logic signed [SampleW-1:0]  az;
    logic [SensW-1:0]           sens;
    logic                       win_done;
    logic                       win_idle;
    logic                       win_filling;
    logic                       win_ready;

    // word layout: accel x in the top bits down to gyro z in the bottom bits
    always_comb
    begin
        if (state_reg == T_MAG_G)
        begin
            ax = sample_reg[47:32];
            ay = sample_reg[31:16];
            az = sample_reg[15:0];
            sens = g_sens_reg;
        end
        else
        begin
            ax = sample_reg[95:80];
            ay = sample_reg[79:64];
            az = sample_reg[63:48];
            sens = a_sens_reg;
        end
    end

    iid_mag_unit u_mag (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mag_start),
        .ax    (ax),
        .ay    (ay),
        .az    (az),
        .sens  (sens),
        .done  (mag_done),
        .mag   (mag)
    );

    iid_window #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_win (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == T_MAG_G && mag_done),
        .mag_a    (mag_a_reg),
        .mag_g    (mag),
        .window   (win_reg),
        .acc_low  (a_low_reg),
        .acc_high (a_high_reg),
        .gyr_high (g_high_reg),
        .done     (win_done),
        .is_idle  (win_idle),
        .filling  (win_filling)
    );

    // window block is ready once its clearing pass has ended; track that here
    logic clear_done_reg;
    logic [$clog2(HISTORY_DEPTH+1)-1:0] clr_cnt_reg;
    assign win_ready = clear_done_reg;

    // unit start is raised on entering each magnitude state and drops once started_reg is set
    logic started_reg;
    assign mag_start = (state_reg == T_MAG_A || state_reg == T_MAG_G) && !started_reg;

    assign in_ch.ready = (state_reg == T_IDLE) && win_ready;
    assign out_ch.valid = (state_reg == T_OUT);
    assign out_ch.data = {is_idle_reg, filling_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            started_reg <= 1'b0;
            clear_done_reg <= 1'b0;
            clr_cnt_reg <= '0;
            a_sens_reg <= AccelSensReset;
            g_sens_reg <= GyroSensReset;
            win_reg <= WindowReset;
            a_low_reg <= AccelLowReset;
            a_high_reg <= AccelHighReset;
            g_high_reg <= GyroHighReset;
            is_idle_reg <= 1'b0;
            filling_reg <= 1'b0;
        end
        else
        begin
            if (!clear_done_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (32'(clr_cnt_reg) == HISTORY_DEPTH)
                    clear_done_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    RegAccelSens: a_sens_reg <= cfg_data;
                    RegGyroSens:  g_sens_reg <= cfg_data;
                    RegWindow:    win_reg <= cfg_data[WinW-1:0];
                    RegAccelLow:  a_low_reg <= cfg_data[LimW-1:0];
                    RegAccelHigh: a_high_reg <= cfg_data[LimW-1:0];
                    RegGyroHigh:  g_high_reg <= cfg_data[LimW-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        sample_reg <= in_ch.data;
                        started_reg <= 1'b0;
                        state_reg <= T_MAG_A;
                    end
                end
                T_MAG_A:
                begin
                    started_reg <= 1'b1;
                    if (mag_done)
                    begin
                        mag_a_reg <= mag;
                        started_reg <= 1'b0;
                        state_reg <= T_MAG_G;
                    end
                end
                T_MAG_G:
                begin
                    started_reg <= 1'b1;
                    if (mag_done)
                        state_reg <= T_WIN;
                end
                T_WIN:
                begin
                    if (win_done)
                    begin
                        is_idle_reg <= win_idle;
                        filling_reg <= win_filling;
                        state_reg <= T_OUT;
                    end
                end
                T_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= T_IDLE;
                end
                default:
                    state_reg <= T_IDLE;
            endcase
        end
    end

endmodule
